@@ rtl/binary_to_decimal_ascii_top_defines.svh @@
// Assertion macros shared by the binary-to-decimal ASCII block.
// No dependencies; included by files that carry concurrent assertions.
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// antecedent holds -> consequent holds in the same cycle
`define B2DA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("b2da assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define B2DA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("b2da assertion failed");

`endif

@@ rtl/b2da_pkg.sv @@
// Shared constants and types for the binary-to-decimal ASCII block.
// No dependencies; used by the channel interfaces and all modules.
package b2da_pkg;

   localparam int VALUE_BITS = 64;
   localparam int INPUT_W    = 64;
   localparam int BCD_DIGITS = 20;
   localparam int DIGIT_W    = 4;
   localparam int CHAR_W     = 6;
   localparam int CNT_W      = $clog2(VALUE_BITS);
   localparam int REM_W      = $clog2(BCD_DIGITS + 1);

   localparam logic [CNT_W-1:0]   CNT_INIT   = CNT_W'(VALUE_BITS - 1);
   localparam logic [CNT_W-1:0]   CNT_ONE    = CNT_W'(1);
   localparam logic [REM_W-1:0]   REM_INIT   = REM_W'(BCD_DIGITS);
   localparam logic [REM_W-1:0]   REM_ONE    = REM_W'(1);
   localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;
   localparam logic [DIGIT_W-1:0] DABBLE_MIN = 4'd5;
   localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;
   localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
   localparam logic [CHAR_W-1:0]  ASCII_NINE = 6'd57;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear;
      logic dabble;
      logic bit_in;
      logic digit_shift;
   } bcd_ctrl_type;

endpackage

@@ rtl/b2da_channels.sv @@
// Valid/ready channel interfaces for the request and response sides.
// Depends on b2da_pkg for payload widths.
interface b2da_req_if;
   logic                           valid;
   logic                           ready;
   logic [b2da_pkg::INPUT_W-1:0]   value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface b2da_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [b2da_pkg::CHAR_W-1:0]    digit_char;
   logic                           last;

   modport source (output valid, output digit_char, output last, input ready);
   modport sink   (input valid, input digit_char, input last, output ready);
endinterface

@@ rtl/b2da_bcd_shift.sv @@
// BCD digit register: shift-and-add-3 per input bit, digit shift for readout.
// Depends on b2da_pkg.
module b2da_bcd_shift (
   input  logic                           clock,
   input  b2da_pkg::bcd_ctrl_type         ctrl,
   output logic [b2da_pkg::DIGIT_W-1:0]   top_digit
);

   logic [b2da_pkg::BCD_DIGITS-1:0][b2da_pkg::DIGIT_W-1:0] bcd_ff;
   logic [b2da_pkg::BCD_DIGITS-1:0][b2da_pkg::DIGIT_W-1:0] bcd_in;
   logic [b2da_pkg::BCD_DIGITS-1:0][b2da_pkg::DIGIT_W-1:0] adj;

   always_comb begin
      for (int d = 0; d < b2da_pkg::BCD_DIGITS; d++) begin
         adj[d] = (bcd_ff[d] >= b2da_pkg::DABBLE_MIN) ?
                  bcd_ff[d] + b2da_pkg::DABBLE_ADD : bcd_ff[d];
      end
   end

   always_comb begin
      bcd_in = bcd_ff;
      if (ctrl.clear) begin
         bcd_in = '0;
      end else if (ctrl.dabble) begin
         bcd_in[0] = {adj[0][b2da_pkg::DIGIT_W-2:0], ctrl.bit_in};
         for (int d = 1; d < b2da_pkg::BCD_DIGITS; d++) begin
            bcd_in[d] = {adj[d][b2da_pkg::DIGIT_W-2:0], adj[d-1][b2da_pkg::DIGIT_W-1]};
         end
      end else if (ctrl.digit_shift) begin
         bcd_in[0] = '0;
         for (int d = 1; d < b2da_pkg::BCD_DIGITS; d++) begin
            bcd_in[d] = bcd_ff[d-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff <= bcd_in;
   end

   assign top_digit = bcd_ff[b2da_pkg::BCD_DIGITS-1];

endmodule

@@ rtl/binary_to_decimal_ascii_top.sv @@
// Top level: unsigned binary to decimal ASCII digits, most significant first.
// Depends on b2da_pkg, b2da_channels, b2da_bcd_shift and the defines header.
//
//   channel   | dir | payload                 | transfer
//   req_chan  | in  | value[63:0]             | valid && ready
//   rsp_chan  | out | digit_char[5:0], last   | valid && ready
//
// An item is accepted in idle, converted by bit-serial shift-and-add-3 over
// all 64 input bits, then read out: leading zeros shifted out one a cycle,
// a move from skip to emit, then one digit a cycle while the output register
// is free. The conversion loop dominates the time per item.
// Synchronous reset clears the FSM and the output valid; no clearing pass.
// A stalled response holds in the output register; a new value is accepted
// while the last digit of the previous one still waits.
`include "binary_to_decimal_ascii_top_defines.svh"

module binary_to_decimal_ascii_top (
   input  logic         clock,
   input  logic         reset,
   b2da_req_if.sink     req_chan,
   b2da_rsp_if.source   rsp_chan
);

   b2da_pkg::state_type                state_ff, state_in;
   logic [b2da_pkg::VALUE_BITS-1:0]    value_ff, value_in;
   logic [b2da_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic [b2da_pkg::REM_W-1:0]         remain_ff, remain_in;
   logic                               out_valid_ff;
   logic [b2da_pkg::CHAR_W-1:0]        out_char_ff, out_char_in;
   logic                               out_last_ff, out_last_in;
   logic                               load;
   logic                               slot_free;
   logic                               skip_zero;
   logic [b2da_pkg::DIGIT_W-1:0]       top_digit;
   logic [b2da_pkg::DIGIT_W-1:0]       clamp_digit;
   b2da_pkg::bcd_ctrl_type             ctrl;

   b2da_bcd_shift u_bcd (
      .clock     (clock),
      .ctrl      (ctrl),
      .top_digit (top_digit)
   );

   assign slot_free   = !out_valid_ff || rsp_chan.ready;
   assign skip_zero   = (top_digit == '0) && (remain_ff > b2da_pkg::REM_ONE);
   assign clamp_digit = (top_digit > b2da_pkg::DIGIT_MAX) ? b2da_pkg::DIGIT_MAX : top_digit;
   assign out_char_in = b2da_pkg::ASCII_ZERO + {2'b00, clamp_digit};
   assign out_last_in = (remain_ff == b2da_pkg::REM_ONE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         b2da_pkg::ST_IDLE: begin
            if (req_chan.valid) state_in = b2da_pkg::ST_CONVERT;
         end
         b2da_pkg::ST_CONVERT: begin
            if (cnt_ff == '0) state_in = b2da_pkg::ST_SKIP;
         end
         b2da_pkg::ST_SKIP: begin
            if (!skip_zero) state_in = b2da_pkg::ST_EMIT;
         end
         b2da_pkg::ST_EMIT: begin
            if (slot_free && out_last_in) state_in = b2da_pkg::ST_IDLE;
         end
         default: state_in = b2da_pkg::ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      req_chan.ready   = 1'b0;
      ctrl             = '0;
      ctrl.bit_in      = value_ff[b2da_pkg::VALUE_BITS-1];
      value_in         = value_ff;
      cnt_in           = cnt_ff;
      remain_in        = remain_ff;
      load             = 1'b0;
      case (state_ff)
         b2da_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               ctrl.clear = 1'b1;
               value_in   = req_chan.value[b2da_pkg::VALUE_BITS-1:0];
               cnt_in     = b2da_pkg::CNT_INIT;
               remain_in  = b2da_pkg::REM_INIT;
            end
         end
         b2da_pkg::ST_CONVERT: begin
            ctrl.dabble = 1'b1;
            value_in    = {value_ff[b2da_pkg::VALUE_BITS-2:0], 1'b0};
            cnt_in      = cnt_ff - b2da_pkg::CNT_ONE;
         end
         b2da_pkg::ST_SKIP: begin
            if (skip_zero) begin
               ctrl.digit_shift = 1'b1;
               remain_in        = remain_ff - b2da_pkg::REM_ONE;
            end
         end
         b2da_pkg::ST_EMIT: begin
            if (slot_free) begin
               load             = 1'b1;
               ctrl.digit_shift = 1'b1;
               remain_in        = remain_ff - b2da_pkg::REM_ONE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= b2da_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      cnt_ff    <= cnt_in;
      remain_ff <= remain_in;
      if (load) begin
         out_char_ff <= out_char_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.digit_char = out_char_ff;
   assign rsp_chan.last       = out_last_ff;

   `B2DA_ASSERT_NEXT(a_accept_starts, clock, reset, req_chan.valid && req_chan.ready,
                     state_ff == b2da_pkg::ST_CONVERT)
   `B2DA_ASSERT_NEXT(a_convert_ends, clock, reset,
                     state_ff == b2da_pkg::ST_CONVERT && cnt_ff == '0,
                     state_ff == b2da_pkg::ST_SKIP)
   `B2DA_ASSERT_SAME(a_char_range, clock, reset, out_valid_ff,
                     out_char_ff >= b2da_pkg::ASCII_ZERO && out_char_ff <= b2da_pkg::ASCII_NINE)
   `B2DA_ASSERT_SAME(a_digits_left, clock, reset,
                     state_ff == b2da_pkg::ST_SKIP || state_ff == b2da_pkg::ST_EMIT,
                     remain_ff != '0)

endmodule

@@ tb/decimal_text_scoreboard_pkg.sv @@
// Scoreboard for the binary-to-decimal ASCII block: expected digit characters.
// Depends on b2da_pkg for the character, input and value widths and the ASCII zero code.
package decimal_text_scoreboard_pkg;

   localparam int DECIMAL_BASE = 10;
   localparam int CHAR_W       = b2da_pkg::CHAR_W;
   localparam int INPUT_W      = b2da_pkg::INPUT_W;
   localparam int VALUE_BITS   = b2da_pkg::VALUE_BITS;

   class decimal_text_scoreboard;
      typedef struct packed {
         logic [CHAR_W-1:0] digit_char;
         logic              last;
      } digit_item_type;

      digit_item_type pending_digits[$];
      int             errors;

      function new();
         errors = 0;
      endfunction

      // Split one accepted value into its decimal characters, MSD first.
      function void add_value(logic [INPUT_W-1:0] value);
         logic [INPUT_W-1:0] rest;
         logic [3:0]         digits[$];
         digit_item_type     item;
         rest = value & ({INPUT_W{1'b1}} >> (INPUT_W - VALUE_BITS));
         do begin
            digits.push_front(4'(rest % DECIMAL_BASE));
            rest = rest / DECIMAL_BASE;
         end while (rest != 0);
         foreach (digits[i]) begin
            item.digit_char = b2da_pkg::ASCII_ZERO + CHAR_W'(digits[i]);
            item.last       = (i == digits.size() - 1);
            pending_digits.push_back(item);
         end
      endfunction

      function void check_digit(realtime stamp, logic [CHAR_W-1:0] digit_char, logic last);
         digit_item_type exp_item;
         if (pending_digits.size() == 0) begin
            $display("%0t ns: unexpected digit transfer, expected none, got char %0d last %0b",
                     stamp, digit_char, last);
            errors++;
            return;
         end
         exp_item = pending_digits.pop_front();
         if (digit_char !== exp_item.digit_char) begin
            $display("%0t ns: digit_char mismatch, expected %0d, got %0d",
                     stamp, exp_item.digit_char, digit_char);
            errors++;
         end
         if (last !== exp_item.last) begin
            $display("%0t ns: last mismatch, expected %0b, got %0b",
                     stamp, exp_item.last, last);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending_digits.size();
      endfunction
   endclass
endpackage

@@ tb/tb.sv @@
// Testbench top for binary_to_decimal_ascii_top: directed and random values,
// random idling on both channels. Depends on b2da_pkg, b2da_channels and the scoreboard.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_VALUES = 360;
   localparam int DRAIN_CYCLES  = 200;
   localparam int IN_W          = b2da_pkg::INPUT_W;

   logic clock;
   logic reset;
   bit   quiet;

   b2da_req_if req_chan ();
   b2da_rsp_if rsp_chan ();

   decimal_text_scoreboard_pkg::decimal_text_scoreboard digits_sb;

   binary_to_decimal_ascii_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("binary_to_decimal_ascii_top regression: fail");
      $finish;
   end

   function automatic logic [IN_W-1:0] power_of_ten(int exponent);
      logic [IN_W-1:0] p;
      p = IN_W'(1);
      repeat (exponent) p = p * decimal_text_scoreboard_pkg::DECIMAL_BASE;
      return p;
   endfunction

   function automatic logic [IN_W-1:0] random_value();
      logic [IN_W-1:0] v;
      case ($urandom_range(0, 3))
         0: v = {$urandom, $urandom};
         1: v = {$urandom, $urandom} >> $urandom_range(0, 63);
         2: begin
            v = power_of_ten($urandom_range(0, 19));
            if ($urandom_range(0, 1)) v = v - IN_W'(1);
         end
         default: v = IN_W'($urandom_range(0, 999));
      endcase
      return v;
   endfunction

   task automatic send_value(logic [IN_W-1:0] value);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.value <= value;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      digits_sb.add_value(value);
   endtask

   task automatic wait_for_drain();
      while (digits_sb.outstanding() != 0) @(posedge clock);
   endtask

   task automatic receive_digits();
      int stall;
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         digits_sb.check_digit($realtime, rsp_chan.digit_char, rsp_chan.last);
      end
   endtask

   initial begin
      logic [IN_W-1:0] directed_values[$];
      digits_sb      = new();
      quiet          = 1'b0;
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.value = '0;
      rsp_chan.ready = 1'b0;

      directed_values = '{
         64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100,
         64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
         64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
         64'd10000000000000000000, 64'd9999999999999999999,
         64'd12345678901234567890, 64'd999999999, 64'd1000000000,
         64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
         64'h0000_0001_0000_0000, 64'h0000_0000_FFFF_FFFF,
         64'd5, 64'd55, 64'd4294967296
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      fork
         receive_digits();
      join_none

      foreach (directed_values[i]) send_value(directed_values[i]);

      for (int i = 0; i < RANDOM_VALUES; i++) begin
         quiet = (i >= 60 && i < 100) || (i >= 250 && i < 270);
         if (i == RANDOM_VALUES / 2) begin
            // hold the request side until every digit has drained
            req_chan.valid <= 1'b0;
            wait_for_drain();
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
         send_value(random_value());
      end
      quiet = 1'b0;
      req_chan.valid <= 1'b0;

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (digits_sb.errors == 0 && digits_sb.outstanding() == 0) begin
         $display("binary_to_decimal_ascii_top regression: pass");
      end else begin
         $display("binary_to_decimal_ascii_top regression: fail");
      end
      $finish;
   end
endmodule

@@ binary_to_decimal_ascii_top.f @@
+incdir+rtl
rtl/b2da_pkg.sv
rtl/b2da_channels.sv
rtl/b2da_bcd_shift.sv
rtl/binary_to_decimal_ascii_top.sv
tb/decimal_text_scoreboard_pkg.sv
tb/tb.sv
